### src/brc_pkg.sv
// Shared types and constants for the binary range encoder.
package brc_pkg;

  localparam int PROB_W      = 12;  // width of the prob_zero field
  localparam int PROB_EXT_W  = 16;  // prob after clamping, covers PROB_WIDTH up to 16
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;
  localparam int FLUSH_CNT_W = 3;

  localparam logic [31:0] TOP_LIMIT  = 32'h0100_0000;
  localparam logic [31:0] FULL_RANGE = 32'hFFFF_FFFF;
  localparam logic [7:0]  TOP_BYTE   = 8'hFF;

  localparam logic [FLUSH_CNT_W-1:0] FLUSH_LAST = 3'd4;  // five settling steps: 0..4

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  typedef struct packed {
    logic [7:0]  lead_byte;
    logic [31:0] run_count;
    logic        run_is_zero;
  } brc_result_t;

endpackage

### src/brc_bound.sv
// Probability clamp and bound multiplier with a registered product.
module brc_bound import brc_pkg::*; #(
  parameter int PROB_WIDTH = 12
) (
  input  logic              clk,
  input  logic              load,
  input  logic [31:0]       range_in,
  input  logic [PROB_W-1:0] prob_in,
  output logic [31:0]       bound
);

  localparam logic [PROB_EXT_W-1:0] ProbMax =
    PROB_EXT_W'((32'd1 << PROB_WIDTH) - 32'd1);

  logic [PROB_EXT_W-1:0]    prob_ext;
  logic [PROB_EXT_W-1:0]    prob_c;
  logic [31:0]              range_sh;
  logic [31+PROB_EXT_W:0]   product;
  logic [31:0]              bound_r;

  always_comb begin
    prob_ext = PROB_EXT_W'(prob_in);
    if (prob_ext == '0) begin
      prob_c = PROB_EXT_W'(1);
    end else if (prob_ext > ProbMax) begin
      prob_c = ProbMax;
    end else begin
      prob_c = prob_ext;
    end
    range_sh = range_in >> PROB_WIDTH;
    product  = {{PROB_EXT_W{1'b0}}, range_sh} * {32'd0, prob_c};
  end

  // product never exceeds range_in, so the low 32 bits hold it exactly
  always_ff @(posedge clk) begin
    if (load) begin
      bound_r <= product[31:0];
    end
  end

  assign bound = bound_r;

endmodule

### src/brc_out_reg.sv
// Result output register on the master-side stream.
module brc_out_reg import brc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  brc_result_t            load_data,
  input  logic                   load_last,
  output logic                   out_free,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  logic        valid_r;
  logic        valid_nxt;
  brc_result_t data_r;
  logic        last_r;

  assign out_free  = !valid_r || out_tready;
  assign valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
      last_r <= load_last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {data_r.run_count, data_r.lead_byte};
  assign out_tuser  = data_r.run_is_zero;
  assign out_tlast  = last_r;

endmodule

### src/binary_range_encoder.sv
// Top level: sequencer and coder state of the binary range encoder.
//
// LZMA-style binary range encoder. Each input transaction either codes one bit
// (in_tuser = 0) under a probability of zero in in_tdata[11:0] (clamped to
// 1 .. 2^PROB_WIDTH-1) with the bit in in_tdata[12], or flushes the coder
// (in_tuser = 1), which emits five settling bytes and returns to reset state.
// Each output transaction carries the cached byte plus carry in out_tdata[7:0]
// and a run count in out_tdata[39:8] of following bytes that are 0x00 when
// out_tuser is 1 and 0xFF when it is 0; out_tlast marks the final result of an
// input transaction. An encode may produce no output at all. One item is worked
// at a time: an encode is accepted, applied and then renormalized by k = 0..2
// shifts of the shared shift/settle step before the next item is accepted; a
// flush runs that step and its settling steps. The bound multiply is registered.
// The sequencer stalls whenever a result is ready to move and the output
// register has not been taken.
module binary_range_encoder import brc_pkg::*; #(
  parameter int PROB_WIDTH = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [11:0] prob_zero, [12] bit_value
  input  logic                   in_tuser,   // [0] cmd
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] lead_byte, [39:8] run_count
  output logic                   out_tuser,  // [0] run_is_zero
  output logic                   out_tlast
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_NORM,
    ST_FLUSH,
    ST_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  logic [32:0]            low_r, low_nxt;
  logic [31:0]            range_r, range_nxt;
  logic [7:0]             cache_r, cache_nxt;
  logic [31:0]            pending_r, pending_nxt;
  logic                   flush_r, flush_nxt;
  logic                   bit_r, bit_nxt;
  logic [FLUSH_CNT_W-1:0] fcnt_r, fcnt_nxt;
  brc_result_t            held_r, held_nxt;
  logic                   held_v_r, held_v_nxt;

  logic        accept;
  logic [31:0] bound;
  logic        out_free;
  logic        out_load;
  logic        out_last;
  logic        carry;
  logic        settle_cond;
  logic        emit_ok;
  logic        step;
  brc_result_t cur_result;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  brc_bound #(
    .PROB_WIDTH (PROB_WIDTH)
  ) u_bound (
    .clk      (clk),
    .load     (accept && (in_tuser == CMD_ENCODE)),
    .range_in (range_r),
    .prob_in  (in_tdata[PROB_W-1:0]),
    .bound    (bound)
  );

  brc_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (out_load),
    .load_data  (held_r),
    .load_last  (out_last),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // One result is held back until the next one (or the end) tells us its last flag.
  always_comb begin
    carry                  = low_r[32];
    settle_cond            = carry || (low_r[31:24] != TOP_BYTE);
    cur_result.lead_byte   = cache_r + {7'b0, carry};
    cur_result.run_count   = pending_r;
    cur_result.run_is_zero = carry;
    emit_ok                = !held_v_r || out_free;

    state_nxt   = state_r;
    low_nxt     = low_r;
    range_nxt   = range_r;
    cache_nxt   = cache_r;
    pending_nxt = pending_r;
    flush_nxt   = flush_r;
    bit_nxt     = bit_r;
    fcnt_nxt    = fcnt_r;
    held_nxt    = held_r;
    held_v_nxt  = held_v_r;
    out_load    = 1'b0;
    out_last    = 1'b0;
    step        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          flush_nxt = (in_tuser == CMD_FLUSH);
          bit_nxt   = in_tdata[PROB_W];
          fcnt_nxt  = '0;
          state_nxt = (in_tuser == CMD_FLUSH) ? ST_NORM : ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (!bit_r) begin
          range_nxt = bound;
        end else begin
          low_nxt   = low_r + {1'b0, bound};
          range_nxt = range_r - bound;
        end
        state_nxt = ST_NORM;
      end
      ST_NORM: begin
        if (range_r < TOP_LIMIT) begin
          if (!settle_cond || emit_ok) begin
            step = 1'b1;
            if (settle_cond) begin
              out_load    = held_v_r;
              held_nxt    = cur_result;
              held_v_nxt  = 1'b1;
              pending_nxt = '0;
              cache_nxt   = low_r[31:24];
            end else if (pending_r != FULL_RANGE) begin
              pending_nxt = pending_r + 32'd1;
            end
            low_nxt   = {1'b0, low_r[23:0], 8'h00};
            range_nxt = {range_r[23:0], 8'h00};
          end
        end else begin
          state_nxt = flush_r ? ST_FLUSH : ST_DONE;
        end
      end
      ST_FLUSH: begin
        if (emit_ok) begin
          step       = 1'b1;
          out_load   = held_v_r;
          held_nxt   = cur_result;
          held_v_nxt = 1'b1;
          if (fcnt_r == FLUSH_LAST) begin
            low_nxt     = '0;
            range_nxt   = FULL_RANGE;
            cache_nxt   = '0;
            pending_nxt = '0;
            state_nxt   = ST_DONE;
          end else begin
            pending_nxt = '0;
            cache_nxt   = low_r[31:24];
            low_nxt     = {1'b0, low_r[23:0], 8'h00};
            range_nxt   = FULL_RANGE;
            fcnt_nxt    = fcnt_r + FLUSH_CNT_W'(1);
            state_nxt   = ST_NORM;
          end
        end
      end
      ST_DONE: begin
        if (!held_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_load   = 1'b1;
          out_last   = 1'b1;
          held_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      low_r     <= '0;
      range_r   <= FULL_RANGE;
      cache_r   <= '0;
      pending_r <= '0;
      flush_r   <= 1'b0;
      bit_r     <= 1'b0;
      fcnt_r    <= '0;
      held_v_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      low_r     <= low_nxt;
      range_r   <= range_nxt;
      cache_r   <= cache_nxt;
      pending_r <= pending_nxt;
      flush_r   <= flush_nxt;
      bit_r     <= bit_nxt;
      fcnt_r    <= fcnt_nxt;
      held_v_r  <= held_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

`ifndef SYNTHESIS
  a_idle_nothing_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !held_v_r)
    else $error("result still held while idle");

  a_idle_normalized: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (range_r >= TOP_LIMIT))
    else $error("range not normalized while idle");

  a_flush_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && fcnt_r == FLUSH_LAST && step) |=>
      (low_r == '0 && pending_r == '0 && cache_r == '0 && range_r == FULL_RANGE))
    else $error("flush did not return coder to reset state");

  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("output register overwritten");
`endif

endmodule
